// ----- hw/rtl/wdtds_pkg.sv -----
// ----------------------------------------------------------------------------
// wdtds_pkg
// shared widths, constants and the selection result type for the watchdog
// timeout divider selection block
// ----------------------------------------------------------------------------
package wdtds_pkg;

	localparam int unsigned MS_W     = 16;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned RELOAD_W = 12;
	localparam int unsigned ACT_W    = 15;

	// tick count of a 40 kHz clock over 65535 ms fits in 22 bits
	localparam int unsigned TICK_W   = 22;
	// count per divider step, one bit above the reload field for the saturated 4096
	localparam int unsigned COUNT_W  = RELOAD_W + 1;

	localparam int unsigned NUM_DIV  = 7;
	localparam int unsigned DIV_SHIFT_MIN = 2;

	localparam logic [CODE_W-1:0]  CODE_MAX    = CODE_W'(NUM_DIV - 1);
	localparam logic [COUNT_W-1:0] RELOAD_MAX  = COUNT_W'(13'h0FFF);
	localparam logic [COUNT_W-1:0] RELOAD_SPAN = COUNT_W'(13'h1000);

	// scaled ticks: count << (code + 2), up to 2^20
	localparam int unsigned SCALED_W = COUNT_W + DIV_SHIFT_MIN + NUM_DIV - 1;
	// floor(y / 5) as (y * RECIP5) >> RECIP5_SH, exact for y below 2^18
	localparam int unsigned QUOT_IN_W = SCALED_W - 3;
	localparam int unsigned RECIP5_W  = 18;
	localparam logic [RECIP5_W-1:0] RECIP5 = RECIP5_W'(209716);
	localparam int unsigned RECIP5_SH = 20;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [COUNT_W-1:0] count;
	} wdtds_sel_t;

endpackage

// ----- hw/rtl/wdtds_select.sv -----
// ----------------------------------------------------------------------------
// wdtds_select
// converts ms to 40 kHz ticks and picks the smallest divider whose rounded-up
// step count fits the reload register
// ----------------------------------------------------------------------------
module wdtds_select
	import wdtds_pkg::*;
(
	input  logic [MS_W-1:0] req_ms,
	output wdtds_sel_t      sel
);

	logic [TICK_W-1:0]  ticks;
	logic [TICK_W:0]    rounded [NUM_DIV];
	logic [COUNT_W-1:0] cnt     [NUM_DIV];
	logic [NUM_DIV-1:0] fits;

	// ms * 40 as (ms << 5) + (ms << 3)
	assign ticks = (TICK_W'(req_ms) << 5) + (TICK_W'(req_ms) << 3);

	always_comb begin
		for (int c = 0; c < NUM_DIV; c++) begin
			rounded[c] = {1'b0, ticks} + ((TICK_W+1)'(1) << (c + DIV_SHIFT_MIN))
				- (TICK_W+1)'(1);
			rounded[c] = rounded[c] >> (c + DIV_SHIFT_MIN);
			// fit test on the full quotient before truncation
			fits[c] = (rounded[c] <= (TICK_W+1)'(RELOAD_MAX));
			cnt[c]  = rounded[c][COUNT_W-1:0];
			// zero request raised to one step
			if (rounded[c] == '0) begin
				cnt[c] = COUNT_W'(1);
			end
		end
	end

	// smallest fitting divider wins, otherwise saturate
	always_comb begin
		sel.code  = CODE_MAX;
		sel.count = RELOAD_SPAN;
		for (int c = NUM_DIV - 1; c >= 0; c--) begin
			if (fits[c]) begin
				sel.code  = CODE_W'(c);
				sel.count = cnt[c];
			end
		end
	end

endmodule

// ----- hw/rtl/wdtds_ms_calc.sv -----
// ----------------------------------------------------------------------------
// wdtds_ms_calc
// achieved timeout in whole ms: floor(count * divider / 40)
// ----------------------------------------------------------------------------
module wdtds_ms_calc
	import wdtds_pkg::*;
(
	input  wdtds_sel_t       sel,
	output logic [ACT_W-1:0] actual_ms
);

	logic [CODE_W:0]               shamt;
	logic [SCALED_W-1:0]           scaled;
	logic [QUOT_IN_W-1:0]          eighth;
	logic [QUOT_IN_W+RECIP5_W-1:0] prod;

	// shift of up to 8 needs one bit above the code
	assign shamt  = {1'b0, sel.code} + (CODE_W+1)'(DIV_SHIFT_MIN);
	// count * divider, divider = 4 << code
	assign scaled = SCALED_W'(sel.count) << shamt;
	// divide by 40 as divide by 8 then by 5
	assign eighth = scaled[SCALED_W-1:3];
	assign prod   = (QUOT_IN_W+RECIP5_W)'(eighth) * (QUOT_IN_W+RECIP5_W)'(RECIP5);
	assign actual_ms = prod[RECIP5_SH +: ACT_W];

endmodule

// ----- hw/rtl/watchdog_timeout_divider_select.sv -----
// ----------------------------------------------------------------------------
// watchdog_timeout_divider_select
// maps a requested watchdog timeout in ms to a prescaler divider code, a
// reload value and the achieved timeout for a 40 kHz watchdog clock
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | beat fields
//  ---------+---------------------+------------------------------------------
//  request  | in_valid / in_ready | req_ms
//  result   | out_valid/out_ready | divider_code, reload_word, actual_ms
//
//  one beat in, one beat out; an accepted request is held in the input register,
//  then loaded into the result register and presented on the result port, and a
//  new request can be taken every cycle while the result is not stalled
//  the rate is set by the single pass between the input register and the
//  result register (divider compare and one constant multiply)
//  arst_n clears both valid flags; payload registers are not reset
//  a stalled result holds and the input register still takes a request when
//  the result is drained in the same cycle
//
module watchdog_timeout_divider_select
	import wdtds_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic [MS_W-1:0]     req_ms,

	output logic                out_valid,
	input  logic                out_ready,
	output logic [CODE_W-1:0]   divider_code,
	output logic [RELOAD_W-1:0] reload_word,
	output logic [ACT_W-1:0]    actual_ms
);

	// input register
	logic              valid_s1;
	logic [MS_W-1:0]   req_ms_s1;

	// result register
	logic                out_valid_q;
	logic [CODE_W-1:0]   divider_code_q;
	logic [RELOAD_W-1:0] reload_word_q;
	logic [ACT_W-1:0]    actual_ms_q;

	wdtds_sel_t        sel;
	logic [ACT_W-1:0]  act_ms;
	logic              res_load;

	// result slot is free when empty or drained this cycle
	assign res_load = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || res_load;

	wdtds_select u_select (
		.req_ms (req_ms_s1),
		.sel    (sel)
	);

	wdtds_ms_calc u_ms_calc (
		.sel       (sel),
		.actual_ms (act_ms)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_ms_s1 <= req_ms;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load && valid_s1) begin
			divider_code_q <= sel.code;
			// count minus one, so the saturated count 4096 gives 4095
			reload_word_q  <= RELOAD_W'(sel.count - COUNT_W'(1));
			actual_ms_q    <= act_ms;
		end
	end

	assign out_valid    = out_valid_q;
	assign divider_code = divider_code_q;
	assign reload_word  = reload_word_q;
	assign actual_ms    = actual_ms_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for watchdog_timeout_divider_select: a queue-fed driver
// offers timeout requests, a monitor predicts the divider code, reload value
// and achieved timeout of every accepted request and checks each result beat
// in order, across phases of sender gaps, receiver stalls and back-pressure
// ----------------------------------------------------------------------------
module testbench;
	import wdtds_pkg::*;

	// watchdog clock and time base of the prediction
	localparam int unsigned WDT_CLK_HZ   = 40000;
	localparam int unsigned MS_PER_S     = 1000;
	localparam int unsigned TICKS_PER_MS = WDT_CLK_HZ / MS_PER_S;
	localparam int unsigned DIV_LOW      = 4;
	localparam int unsigned COUNT_LIMIT  = 4095;
	localparam int unsigned SAT_COUNT    = 4096;
	localparam int unsigned DIV_HIGH     = 256;

	// bench knobs
	localparam int unsigned HOLD_CYCLES    = 64;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES    = 8;
	localparam int unsigned PHASE_ITEMS    = 357;

	typedef struct packed {
		logic [CODE_W-1:0]   code;
		logic [RELOAD_W-1:0] reload;
		logic [ACT_W-1:0]    act;
	} sel_result_t;

	// one pending request plus the idling that goes with it
	typedef struct {
		logic [MS_W-1:0] ms;
		int unsigned     gap_pct;
		int unsigned     stall_pct;
		bit              drain_first;
		bit              hold_rx;
	} request_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [MS_W-1:0]     req_ms = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CODE_W-1:0]   divider_code;
	logic [RELOAD_W-1:0] reload_word;
	logic [ACT_W-1:0]    actual_ms;

	request_t    request_q[$];
	sel_result_t pending_sel_q[$];

	bit          req_taken = 1'b0;
	int unsigned mismatch_cnt = 0;
	int unsigned quiet_cycles = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_seq = 0;
	int unsigned hold_ack = 0;
	int unsigned hold_left = 0;

	watchdog_timeout_divider_select u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_ms       (req_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.divider_code (divider_code),
		.reload_word  (reload_word),
		.actual_ms    (actual_ms)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// largest request in ms that still fits the reload field with divider code k
	function automatic int unsigned fit_limit(input int unsigned k);
		return (COUNT_LIMIT * (DIV_LOW << k)) / TICKS_PER_MS;
	endfunction

	// smallest divider whose rounded-up tick count fits, else saturate
	function automatic sel_result_t select_divider(input logic [MS_W-1:0] ms);
		sel_result_t r;
		logic [63:0] ticks;
		logic [63:0] div;
		logic [63:0] count;
		int          k;
		ticks    = 64'(ms) * TICKS_PER_MS;
		r.code   = CODE_W'(NUM_DIV - 1);
		r.reload = RELOAD_W'(COUNT_LIMIT);
		r.act    = ACT_W'((64'(SAT_COUNT) * DIV_HIGH * MS_PER_S) / WDT_CLK_HZ);
		// walk down so the last fit seen is the smallest divider
		for (k = NUM_DIV - 1; k >= 0; k--) begin
			div   = 64'(DIV_LOW) << k;
			count = (ticks + div - 1) / div;
			// zero request still needs one tick
			if (count == 0)
				count = 1;
			if (count <= COUNT_LIMIT) begin
				r.code   = CODE_W'(k);
				r.reload = RELOAD_W'(count - 1);
				r.act    = ACT_W'((count * div * MS_PER_S) / WDT_CLK_HZ);
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus generation
	// ------------------------------------------------------------------

	// mostly inside one divider's range, some right at a fit boundary,
	// some anywhere in the 16-bit range (saturation) and some tiny ones
	function automatic logic [MS_W-1:0] pick_timeout();
		int unsigned k;
		int unsigned v;
		k = $urandom_range(NUM_DIV - 1);
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: v = $urandom_range(fit_limit(k));
			6, 7:             v = fit_limit(k) + $urandom_range(4) - 2;
			8:                v = $urandom_range(65535);
			default:          v = $urandom_range(40);
		endcase
		return MS_W'(v);
	endfunction

	task automatic queue_request(input logic [MS_W-1:0] ms, input int unsigned gap,
			input int unsigned stall, input bit drain, input bit hold);
		request_t r;
		r.ms          = ms;
		r.gap_pct     = gap;
		r.stall_pct   = stall;
		r.drain_first = drain;
		r.hold_rx     = hold;
		request_q.push_back(r);
	endtask

	// a phase of random requests; drain_at and hold_at pick one beat each, -1 for none
	task automatic queue_phase(input int unsigned gap, input int unsigned stall,
			input int drain_at, input int hold_at);
		int i;
		for (i = 0; i < PHASE_ITEMS; i++)
			queue_request(pick_timeout(), gap, stall, i == drain_at, i == hold_at);
	endtask

	// ------------------------------------------------------------------
	// driver: offers the next request at the falling edge once the
	// previous beat has gone, honoring gaps and drain pauses
	// ------------------------------------------------------------------
	request_t drv_req;
	bit       drv_offer;

	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			drv_offer = 1'b0;
			if (request_q.size() != 0) begin
				// a drain pause waits for every outstanding result
				if (!(request_q[0].drain_first && pending_sel_q.size() != 0) &&
						$urandom_range(99) >= request_q[0].gap_pct)
					drv_offer = 1'b1;
			end
			if (drv_offer) begin
				drv_req = request_q.pop_front();
				in_valid     <= 1'b1;
				req_ms       <= drv_req.ms;
				rx_stall_pct <= drv_req.stall_pct;
				// ask the receiver for a long hold-off while we keep sending
				if (drv_req.hold_rx)
					hold_seq <= hold_seq + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stalls, plus a long hold when the driver asks
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seq != hold_ack) begin
				hold_ack  = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: predicts on every request beat, checks every result beat
	// against the oldest prediction, and guards against a hang
	// ------------------------------------------------------------------
	sel_result_t want;
	bit          res_taken;

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken = in_valid && in_ready;
			res_taken = out_valid && out_ready;
			if (req_taken)
				pending_sel_q.push_back(select_divider(req_ms));
			if (res_taken) begin
				if (pending_sel_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: result beat with nothing expected: %s %0d %0d %0d",
							$realtime, "code reload ms", divider_code,
							reload_word, actual_ms);
				end else begin
					want = pending_sel_q.pop_front();
					if (divider_code !== want.code || reload_word !== want.reload ||
							actual_ms !== want.act) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("%0t: mismatch: expected code %0d reload %0d ms %0d, %s",
								$realtime, want.code, want.reload, want.act,
								$sformatf("got code %0d reload %0d ms %0d",
									divider_code, reload_word, actual_ms));
					end
				end
			end
			// watchdog: any beat on either side counts as progress
			if (req_taken || res_taken)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $realtime, quiet_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence: fill the request queue, reset, wait for the end
	// ------------------------------------------------------------------
	initial begin
		int unsigned k;

		// directed: edges of the field, every divider's fit boundary and
		// the one above it, saturation and the zero request
		queue_request(MS_W'(0), 0, 0, 1'b0, 1'b0);
		queue_request(MS_W'(1), 0, 0, 1'b0, 1'b0);
		queue_request(MS_W'(2), 0, 0, 1'b0, 1'b0);
		for (k = 0; k < NUM_DIV; k++) begin
			queue_request(MS_W'(fit_limit(k)), 0, 0, 1'b0, 1'b0);
			queue_request(MS_W'(fit_limit(k) + 1), 0, 0, 1'b0, 1'b0);
		end
		queue_request(MS_W'(26214), 0, 0, 1'b0, 1'b0);
		queue_request(MS_W'(16'h5555), 0, 0, 1'b0, 1'b0);
		queue_request(MS_W'(16'hAAAA), 0, 0, 1'b0, 1'b0);
		queue_request(MS_W'(16'h7FFF), 0, 0, 1'b0, 1'b0);
		queue_request(MS_W'(16'hFFFF), 0, 0, 1'b0, 1'b0);

		// random phases: back to back with a long receiver hold, sender gaps,
		// receiver stalls after a drain, then light idling on both sides with a drain and a long hold
		queue_phase(0, 0, -1, 50);
		queue_phase(74, 0, -1, -1);
		queue_phase(0, 74, 0, -1);
		queue_phase(12, 12, 0, 100);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all requests sent and every result back
		while (request_q.size() != 0 || in_valid || pending_sel_q.size() != 0)
			@(posedge clk);
		// a little longer to catch stray result beats
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_sel_q.size() != 0)
			mismatch_cnt++;
		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/wdtds_pkg.sv
hw/rtl/wdtds_select.sv
hw/rtl/wdtds_ms_calc.sv
hw/rtl/watchdog_timeout_divider_select.sv
test/testbench.sv
